>>> sv/wlbpe_pkg.sv
// Package for the WAV low-byte payload extractor.
// Holds the item and result types, the parse phases, the status codes and the header constants.
// Depends on nothing.
`default_nettype none

package wlbpe_pkg;

    // Widest supported sample, in bytes (2..4).
    localparam int unsigned MAX_SAMPLE_BYTES = 4;
    localparam logic [15:0] MIN_DEPTH        = 16'd16;
    localparam logic [15:0] MAX_DEPTH        = 16'(MAX_SAMPLE_BYTES * 8);

    localparam logic [31:0] TAG_DATA         = 32'h6461_7461;  // "data"
    localparam logic [5:0]  FIRST_CHUNK_LAST = 6'd11;          // last byte of the RIFF header
    localparam logic [5:0]  FORMAT_POS       = 6'd20;
    localparam logic [5:0]  DEPTH_POS        = 6'd34;
    localparam logic [5:0]  POS_SAT          = 6'd63;
    localparam logic [15:0] FORMAT_PCM       = 16'd1;

    localparam logic [2:0] ST_PAYLOAD   = 3'd0;
    localparam logic [2:0] ST_LAST      = 3'd1;
    localparam logic [2:0] ST_DONE      = 3'd2;
    localparam logic [2:0] ST_BAD_DEPTH = 3'd3;
    localparam logic [2:0] ST_EARLY_END = 3'd4;

    localparam int unsigned TDATA_IN_W  = 8;
    localparam int unsigned TDATA_OUT_W = 40;
    localparam int unsigned TUSER_OUT_W = 4;

    typedef enum logic [5:0] {
        PH_HEADER     = 6'b000001,
        PH_CHUNK_HEAD = 6'b000010,
        PH_SKIP       = 6'b000100,
        PH_DATA_HEAD  = 6'b001000,
        PH_PAYLOAD    = 6'b010000,
        PH_DONE       = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } item_t;

    typedef struct packed {
        logic [7:0]  hidden_byte;
        logic [2:0]  status_code;
        logic        format_warning;
        logic [31:0] bytes_emitted;
    } result_t;

    // Handshake between the input register and the parser.
    typedef struct packed {
        logic  valid;
        logic  advance;
    } stage_ctl_t;

endpackage

`default_nettype wire

>>> sv/wlbpe_in_reg.sv
// Input register stage of the WAV low-byte payload extractor.
// Captures one transaction from the slave side and holds it until the parser advances.
// Depends on wlbpe_pkg.
`default_nettype none

module wlbpe_in_reg (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire wlbpe_pkg::item_t in_item,
    input  wire logic           advance,
    output wlbpe_pkg::stage_ctl_t ctl,
    output wlbpe_pkg::item_t    item
);
    import wlbpe_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Refill whenever the held item leaves or the stage is empty.
    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign ctl.valid   = valid_reg;
    assign ctl.advance = advance;
    assign item        = item_reg;

endmodule

`default_nettype wire

>>> sv/wlbpe_parser.sv
// Parser of the WAV low-byte payload extractor: RIFF chunk walk, header capture and
// payload selection, one file byte per advance. Depends on wlbpe_pkg.
`default_nettype none

module wlbpe_parser (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire wlbpe_pkg::stage_ctl_t ctl,
    input  wire wlbpe_pkg::item_t     item,
    output logic                      res_valid,
    output wlbpe_pkg::result_t        res
);
    import wlbpe_pkg::*;

    logic [5:0]  pos_reg,    pos_next;
    phase_t      phase_reg,  phase_next;
    logic [2:0]  hidx_reg,   hidx_next;
    logic [31:0] tag_reg,    tag_next;
    logic [23:0] len_reg,    len_next;
    logic [31:0] skip_reg,   skip_next;
    logic [15:0] width_reg,  width_next;
    logic [15:0] format_reg, format_next;
    logic [1:0]  bis_reg,    bis_next;
    logic [2:0]  hcnt_reg,   hcnt_next;
    logic [31:0] target_reg, target_next;
    logic [31:0] remain_reg, remain_next;
    logic [31:0] count_reg,  count_next;

    logic [7:0]  b;
    logic [31:0] full_len;
    logic [31:0] skip_dec;
    logic [2:0]  bis_inc;
    logic        done_now;
    logic        last_byte;

    assign b        = item.file_byte;
    assign full_len = {b, len_reg};
    assign skip_dec = (skip_reg == 32'd0) ? 32'd0 : skip_reg - 32'd1;
    assign bis_inc  = {1'b0, bis_reg} + 3'd1;

    always_comb begin
        pos_next    = (pos_reg == POS_SAT) ? POS_SAT : pos_reg + 6'd1;
        phase_next  = phase_reg;
        hidx_next   = hidx_reg;
        tag_next    = tag_reg;
        len_next    = len_reg;
        skip_next   = skip_reg;
        width_next  = width_reg;
        format_next = format_reg;
        bis_next    = bis_reg;
        hcnt_next   = hcnt_reg;
        target_next = target_reg;
        remain_next = remain_reg;
        count_next  = count_reg;
        done_now    = 1'b0;
        last_byte   = 1'b0;
        res_valid   = 1'b0;
        res.hidden_byte    = 8'd0;
        res.status_code    = ST_PAYLOAD;
        res.format_warning = 1'b0;
        res.bytes_emitted  = 32'd0;

        // Header fields are captured by absolute position.
        if (pos_reg == FORMAT_POS)        format_next[7:0]  = b;
        if (pos_reg == FORMAT_POS + 6'd1) format_next[15:8] = b;
        if (pos_reg == DEPTH_POS)         width_next[7:0]   = b;
        if (pos_reg == DEPTH_POS + 6'd1)  width_next[15:8]  = b;

        case (phase_reg)
            PH_HEADER: begin
                if (pos_reg >= FIRST_CHUNK_LAST) begin
                    phase_next = PH_CHUNK_HEAD;
                    hidx_next  = 3'd0;
                    tag_next   = 32'd0;
                    len_next   = 24'd0;
                    skip_next  = 32'd0;
                end
            end
            PH_CHUNK_HEAD: begin
                hidx_next = hidx_reg + 3'd1;
                if (!hidx_reg[2]) begin
                    tag_next = {tag_reg[23:0], b};
                end else begin
                    case (hidx_reg[1:0])
                        2'd0:    len_next[7:0]   = b;
                        2'd1:    len_next[15:8]  = b;
                        2'd2:    len_next[23:16] = b;
                        default: len_next        = len_reg;
                    endcase
                end
                if (hidx_reg == 3'd7) begin
                    if (tag_reg == TAG_DATA) begin
                        if (width_next < MIN_DEPTH || width_next > MAX_DEPTH) begin
                            res_valid       = 1'b1;
                            res.status_code = ST_BAD_DEPTH;
                            phase_next      = PH_DONE;
                        end else begin
                            phase_next  = PH_DATA_HEAD;
                            remain_next = full_len;
                            bis_next    = 2'd0;
                            hcnt_next   = 3'd0;
                            target_next = 32'd0;
                            if (full_len == 32'd0) begin
                                res_valid       = 1'b1;
                                res.status_code = ST_DONE;
                                phase_next      = PH_DONE;
                            end
                        end
                    end else if (full_len == 32'd0) begin
                        hidx_next = 3'd0;
                        tag_next  = 32'd0;
                        len_next  = 24'd0;
                        skip_next = 32'd0;
                    end else begin
                        phase_next = PH_SKIP;
                        skip_next  = full_len;
                    end
                end
            end
            PH_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == 32'd0) begin
                    phase_next = PH_CHUNK_HEAD;
                    hidx_next  = 3'd0;
                    tag_next   = 32'd0;
                    len_next   = 24'd0;
                end
            end
            PH_DATA_HEAD, PH_PAYLOAD: begin
                remain_next = remain_reg - 32'd1;
                if (bis_reg == 2'd0) begin
                    if (phase_reg == PH_DATA_HEAD) begin
                        // Length bytes OR into zero, salt bytes XOR on top of them.
                        target_next = target_reg ^ ({24'd0, b} << {hcnt_reg[1:0], 3'b000});
                        hcnt_next   = hcnt_reg + 3'd1;
                        if (hcnt_reg == 3'd7) begin
                            phase_next = PH_PAYLOAD;
                            if (target_next == 32'd0) begin
                                res_valid       = 1'b1;
                                res.status_code = ST_DONE;
                                done_now        = 1'b1;
                            end
                        end
                    end else begin
                        count_next = count_reg + 32'd1;
                        last_byte  = (count_next == target_reg) || (remain_next == 32'd0) ||
                                     item.end_of_file;
                        res_valid        = 1'b1;
                        res.hidden_byte  = b;
                        res.status_code  = last_byte ? ST_LAST : ST_PAYLOAD;
                        done_now         = last_byte;
                    end
                end
                bis_next = ({10'd0, bis_inc} >= width_next[15:3]) ? 2'd0 : bis_inc[1:0];
                if (!done_now && remain_next == 32'd0) begin
                    res_valid        = 1'b1;
                    res.hidden_byte  = 8'd0;
                    res.status_code  = ST_DONE;
                    done_now         = 1'b1;
                end
                if (done_now) begin
                    phase_next = PH_DONE;
                end
            end
            PH_DONE: begin
                phase_next = PH_DONE;
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase

        if (item.end_of_file && !res_valid && phase_next != PH_DONE) begin
            res_valid       = 1'b1;
            res.status_code = ST_EARLY_END;
        end
        res.format_warning = (format_next != FORMAT_PCM);
        res.bytes_emitted  = count_next;

        // Last byte of a file: return to reset so the next byte opens a new file.
        if (item.end_of_file) begin
            pos_next    = 6'd0;
            phase_next  = PH_HEADER;
            hidx_next   = 3'd0;
            tag_next    = 32'd0;
            len_next    = 24'd0;
            skip_next   = 32'd0;
            width_next  = 16'd0;
            format_next = FORMAT_PCM;
            bis_next    = 2'd0;
            hcnt_next   = 3'd0;
            target_next = 32'd0;
            remain_next = 32'd0;
            count_next  = 32'd0;
        end

        if (!ctl.valid) begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= 6'd0;
            phase_reg  <= PH_HEADER;
            hidx_reg   <= 3'd0;
            tag_reg    <= 32'd0;
            len_reg    <= 24'd0;
            skip_reg   <= 32'd0;
            width_reg  <= 16'd0;
            format_reg <= FORMAT_PCM;
            bis_reg    <= 2'd0;
            hcnt_reg   <= 3'd0;
            target_reg <= 32'd0;
            remain_reg <= 32'd0;
            count_reg  <= 32'd0;
        end else if (ctl.valid && ctl.advance) begin
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            hidx_reg   <= hidx_next;
            tag_reg    <= tag_next;
            len_reg    <= len_next;
            skip_reg   <= skip_next;
            width_reg  <= width_next;
            format_reg <= format_next;
            bis_reg    <= bis_next;
            hcnt_reg   <= hcnt_next;
            target_reg <= target_next;
            remain_reg <= remain_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/wlbpe_out_reg.sv
// Result register of the WAV low-byte payload extractor.
// Holds one result transaction for the master side and tells the parser when it may advance.
// Depends on wlbpe_pkg.
`default_nettype none

module wlbpe_out_reg (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               stage_valid,
    input  wire logic               res_valid,
    input  wire wlbpe_pkg::result_t res,
    output logic                    advance,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output wlbpe_pkg::result_t      out_res
);
    import wlbpe_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Advance only when the held result is gone or leaves this cycle.
    assign advance = stage_valid && (!valid_reg || out_ready);

    always_comb begin
        valid_next = valid_reg && !out_ready;
        if (advance) begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

>>> sv/wav_low_byte_payload_extractor.sv
// Top level of the WAV low-byte payload extractor: input register, parser, result register.
// Depends on wlbpe_pkg, wlbpe_in_reg, wlbpe_parser and wlbpe_out_reg.
//
//   channel  | dir | tdata                                      | tuser / tlast
//   ---------+-----+--------------------------------------------+-------------------------------
//   s_       | in  | [7:0] file_byte                            | tlast = end_of_file
//   m_       | out | [7:0] hidden_byte, [39:8] bytes_emitted    | [2:0] status_code,
//            |     |                                            | [3] format_warning
//
// One file byte per cycle sustained while the master side accepts results. A byte is held in
// the input register until the parser advances; the parser then writes its result into the
// result register, which drives the master side. Bytes that cause no result just pass the parser.
// Reset (aresetn low, synchronous) clears all parse state; no clearing pass is needed.
// A stalled result register holds the parser, and a held input register drops s_tready.
`default_nettype none

module wav_low_byte_payload_extractor (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [wlbpe_pkg::TDATA_IN_W-1:0]      s_tdata,   // [7:0] file_byte
    input  wire logic                                  s_tlast,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [wlbpe_pkg::TDATA_OUT_W-1:0]          m_tdata,   // [7:0] hidden_byte,
                                                                  // [39:8] bytes_emitted
    output logic [wlbpe_pkg::TUSER_OUT_W-1:0]          m_tuser    // [2:0] status_code,
                                                                  // [3] format_warning
);
    import wlbpe_pkg::*;

    item_t      in_item;
    item_t      stage_item;
    stage_ctl_t ctl;
    logic       advance;
    logic       res_valid;
    result_t    res;
    result_t    out_res;

    assign in_item.file_byte   = s_tdata;
    assign in_item.end_of_file = s_tlast;

    // Capture the incoming transaction.
    wlbpe_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .advance  (advance),
        .ctl      (ctl),
        .item     (stage_item)
    );

    // Walk the chunks and pick payload bytes.
    wlbpe_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .item      (stage_item),
        .res_valid (res_valid),
        .res       (res)
    );

    // Hold the result for the master side.
    wlbpe_out_reg u_out_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .stage_valid (ctl.valid),
        .res_valid   (res_valid),
        .res         (res),
        .advance     (advance),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_res     (out_res)
    );

    assign m_tdata = {out_res.bytes_emitted, out_res.hidden_byte};
    assign m_tuser = {out_res.format_warning, out_res.status_code};

    // A stalled result must never be overwritten by the parser.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !advance)
        else $error("parser advanced over a stalled result");

    // A held item that cannot advance blocks the slave side.
    a_hold_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.valid && !advance) |-> !s_tready)
        else $error("input accepted while the stage was blocked");

    // Payload results always count at least the byte they carry.
    a_payload_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[2:0] == ST_PAYLOAD || m_tuser[2:0] == ST_LAST)) |->
        (m_tdata[39:8] != 32'd0))
        else $error("payload result with zero byte count");

    // A result is only loaded on a cycle in which the parser advanced.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid ##1 m_tvalid) |-> $past(advance && res_valid))
        else $error("result appeared without a parsed item");

endmodule

`default_nettype wire

>>> tb/wlbpe_payload_checker.sv
// Checker for the WAV low-byte payload extractor: watches both stream channels, predicts results.
// Keeps its own copy of the parse state and compares every result transaction field by field.
// Depends on wlbpe_pkg.
`default_nettype none

module wlbpe_payload_checker (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    input  wire logic                               s_tready,
    input  wire logic [wlbpe_pkg::TDATA_IN_W-1:0]   s_tdata,   // [7:0] file_byte
    input  wire logic                               s_tlast,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [wlbpe_pkg::TDATA_OUT_W-1:0]  m_tdata,   // [7:0] hidden_byte,
                                                               // [39:8] bytes_emitted
    input  wire logic [wlbpe_pkg::TUSER_OUT_W-1:0]  m_tuser,   // [2:0] status_code,
                                                               // [3] format_warning
    output int                                      mismatches,
    output int                                      outstanding
);
    import wlbpe_pkg::*;

    localparam int PRINT_CAP = 64;

    result_t     predicted_results[$];
    int          fail_cnt = 0;

    // parse state of the predictor
    logic [31:0] pos_cnt;
    phase_t      phase;
    logic [31:0] tag_acc;
    logic [31:0] len_acc;
    logic [31:0] skip_cnt;
    logic [15:0] depth_bits;
    logic [15:0] fmt_code;
    logic [1:0]  smp_byte;
    logic [2:0]  hdr_idx;
    logic [31:0] len_word;
    logic [31:0] salt_word;
    logic [31:0] data_left;
    logic [31:0] emitted;
    logic        done;

    task automatic clear_parse();
        pos_cnt    = '0;
        phase      = PH_HEADER;
        tag_acc    = '0;
        len_acc    = '0;
        skip_cnt   = '0;
        depth_bits = '0;
        fmt_code   = FORMAT_PCM;
        smp_byte   = '0;
        hdr_idx    = '0;
        len_word   = '0;
        salt_word  = '0;
        data_left  = '0;
        emitted    = '0;
        done       = 1'b0;
    endtask

    task automatic open_chunk_head();
        phase    = PH_CHUNK_HEAD;
        skip_cnt = '0;
        tag_acc  = '0;
        len_acc  = '0;
    endtask

    function automatic result_t make_result(input logic [7:0] pb, input logic [2:0] st);
        result_t r;
        r.hidden_byte    = pb;
        r.status_code    = st;
        r.format_warning = (fmt_code != FORMAT_PCM);
        r.bytes_emitted  = emitted;
        return r;
    endfunction

    // Advance the parse by one file byte; queue the result it causes, if any.
    task automatic parse_file_byte(input item_t it);
        logic [31:0] at;
        logic [7:0]  b;
        logic [2:0]  k;
        logic [2:0]  h;
        int          sb;
        bit          got;
        bit          last;
        result_t     r;

        b   = it.file_byte;
        at  = pos_cnt;
        got = 1'b0;
        r   = '0;

        // format code and bit depth are captured by absolute file position
        if (at == 32'(FORMAT_POS))       fmt_code[7:0]    = b;
        if (at == 32'(FORMAT_POS) + 1)   fmt_code[15:8]   = b;
        if (at == 32'(DEPTH_POS))        depth_bits[7:0]  = b;
        if (at == 32'(DEPTH_POS) + 1)    depth_bits[15:8] = b;
        if (pos_cnt != '1) pos_cnt = pos_cnt + 1;

        if (!done) begin
            case (phase)
                PH_HEADER: begin
                    if (at >= 32'(FIRST_CHUNK_LAST)) open_chunk_head();
                end
                PH_CHUNK_HEAD: begin
                    k = skip_cnt[2:0];
                    if (k < 3'd4) tag_acc = {tag_acc[23:0], b};
                    else len_acc = len_acc | (32'(b) << {k[1:0], 3'b000});
                    skip_cnt = 32'(k) + 1;
                    if (k == 3'd7) begin
                        if (tag_acc == TAG_DATA) begin
                            if (depth_bits < MIN_DEPTH || depth_bits > MAX_DEPTH) begin
                                r    = make_result('0, ST_BAD_DEPTH);
                                got  = 1'b1;
                                done = 1'b1;
                            end else begin
                                phase     = PH_DATA_HEAD;
                                data_left = len_acc;
                                smp_byte  = '0;
                                hdr_idx   = '0;
                                len_word  = '0;
                                salt_word = '0;
                                if (data_left == '0) begin
                                    r    = make_result('0, ST_DONE);
                                    got  = 1'b1;
                                    done = 1'b1;
                                end
                            end
                        end else if (len_acc == '0) begin
                            open_chunk_head();
                        end else begin
                            phase    = PH_SKIP;
                            skip_cnt = len_acc;
                        end
                    end
                end
                PH_SKIP: begin
                    if (skip_cnt != '0) skip_cnt = skip_cnt - 1;
                    if (skip_cnt == '0) open_chunk_head();
                end
                default: begin
                    // data chunk: length samples, salt samples, then payload samples
                    sb = int'(depth_bits >> 3);
                    if (sb == 0) sb = 1;
                    data_left = data_left - 1;
                    if (smp_byte == 2'd0) begin
                        if (phase == PH_DATA_HEAD) begin
                            h = hdr_idx;
                            if (h < 3'd4) len_word = len_word | (32'(b) << {h[1:0], 3'b000});
                            else salt_word = salt_word | (32'(b) << {h[1:0], 3'b000});
                            hdr_idx = h + 3'd1;
                            if (h == 3'd7) begin
                                phase = PH_PAYLOAD;
                                if ((len_word ^ salt_word) == '0) begin
                                    r    = make_result('0, ST_DONE);
                                    got  = 1'b1;
                                    done = 1'b1;
                                end
                            end
                        end else begin
                            emitted = emitted + 1;
                            last = (emitted == (len_word ^ salt_word)) || (data_left == '0) ||
                                   it.end_of_file;
                            r    = make_result(b, last ? ST_LAST : ST_PAYLOAD);
                            got  = 1'b1;
                            if (last) done = 1'b1;
                        end
                    end
                    smp_byte = (int'(smp_byte) + 1 >= sb) ? 2'd0 : smp_byte + 2'd1;
                    if (!done && data_left == '0) begin
                        r    = make_result('0, ST_DONE);
                        got  = 1'b1;
                        done = 1'b1;
                    end
                end
            endcase
        end

        // end of file: flag a stream that stopped mid-extraction, then start over
        if (it.end_of_file) begin
            if (!got && !done) begin
                r   = make_result('0, ST_EARLY_END);
                got = 1'b1;
            end
            clear_parse();
        end

        if (got) predicted_results.push_back(r);
    endtask

    task automatic report(input string what, input logic [31:0] seen, input logic [31:0] want);
        fail_cnt++;
        if (fail_cnt <= PRINT_CAP)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, seen, want);
    endtask

    always @(posedge aclk) begin
        result_t seen;
        result_t want;

        if (!aresetn) begin
            clear_parse();
            predicted_results.delete();
        end else begin
            // compare first: a result never belongs to a byte accepted at the same edge
            if (m_tvalid && m_tready) begin
                seen = {m_tdata[7:0], m_tuser[2:0], m_tuser[3], m_tdata[39:8]};
                if (predicted_results.size() == 0) begin
                    report("result with none pending, bytes_emitted", seen.bytes_emitted, '0);
                end else begin
                    want = predicted_results.pop_front();
                    if (seen.hidden_byte != want.hidden_byte)
                        report("hidden_byte", 32'(seen.hidden_byte), 32'(want.hidden_byte));
                    if (seen.status_code != want.status_code)
                        report("status_code", 32'(seen.status_code), 32'(want.status_code));
                    if (seen.format_warning != want.format_warning)
                        report("format_warning", 32'(seen.format_warning),
                               32'(want.format_warning));
                    if (seen.bytes_emitted != want.bytes_emitted)
                        report("bytes_emitted", seen.bytes_emitted, want.bytes_emitted);
                end
            end
            if (s_tvalid && s_tready) parse_file_byte({s_tdata[7:0], s_tlast});
        end
        outstanding <= predicted_results.size();
        mismatches  <= fail_cnt;
    end

endmodule

`default_nettype wire

>>> tb/tb_wav_low_byte_payload_extractor.sv
// Testbench top for the WAV low-byte payload extractor: builds WAV byte streams and drives them.
// Depends on wlbpe_pkg, wav_low_byte_payload_extractor and wlbpe_payload_checker.
`default_nettype none

module tb_wav_low_byte_payload_extractor;
    import wlbpe_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_BYTES = 1050;
    localparam int DRAIN_CYCLES = 16;
    // a correct run stays well under this limit even with every gap and stall at its longest
    localparam int CYCLE_LIMIT  = 1_000_000;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;  // "RIFF"
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;  // "WAVE"
    localparam logic [31:0] TAG_FMT  = 32'h666d_7420;  // "fmt "

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata  = '0;     // [7:0] file_byte
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;           // [7:0] hidden_byte, [39:8] bytes_emitted
    logic [TUSER_OUT_W-1:0] m_tuser;           // [2:0] status_code, [3] format_warning

    int    mismatches;
    int    outstanding;
    int    cycle_cnt   = 0;
    int    sink_hold   = 0;
    bit    sink_stalls = 1'b0;
    bit    src_gaps    = 1'b0;
    item_t file_q[$];

    always #CLK_HALF aclk = ~aclk;

    wav_low_byte_payload_extractor u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    wlbpe_payload_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: stall m_tready in random bursts while stalls are enabled.
    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_tready  <= 1'b0;
        end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
            sink_hold <= pick_gap();
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic put_byte(input logic [7:0] b);
        file_q.push_back({b, 1'b0});
    endtask

    // little-endian field of n bytes
    task automatic put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) put_byte(v[8*i +: 8]);
    endtask

    // four-character tag, first character first
    task automatic put_tag(input logic [31:0] t);
        for (int i = 3; i >= 0; i--) put_byte(t[8*i +: 8]);
    endtask

    // flag the last byte of the file
    task automatic mark_eof();
        item_t it;
        it = file_q.pop_back();
        it.end_of_file = 1'b1;
        file_q.push_back(it);
    endtask

    // drop bytes from the end so the file stops early
    task automatic cut_file(input int keep);
        while (file_q.size() > keep) void'(file_q.pop_back());
        mark_eof();
    endtask

    // Build one WAV file: RIFF header, optional fmt chunk (format code at byte 20, depth at
    // byte 34), filler chunks of length 0..9, then the data chunk whose low sample bytes carry
    // the masked length, the salt and the payload. body_len bytes of the data body are written,
    // whatever the size field says, followed by tail_len stray bytes.
    task automatic build_wav(input logic [15:0] fmt, input logic [15:0] depth, input bit with_fmt,
                             input int n_extra, input logic [31:0] body_size,
                             input logic [31:0] msg_len, input int body_len, input int tail_len);
        logic [31:0] salt;
        logic [31:0] tag;
        int          clen;
        int          sb;
        int          idx;
        salt = $urandom();
        put_tag(TAG_RIFF);
        put_le($urandom(), 4);
        put_tag(TAG_WAVE);
        if (with_fmt) begin
            put_tag(TAG_FMT);
            put_le(32'd16, 4);
            put_le(32'(fmt), 2);
            put_le($urandom(), 4);   // channels and half the sample rate
            put_le($urandom(), 4);
            put_le($urandom(), 4);   // rest of byte rate and block align
            put_le(32'(depth), 2);
        end
        repeat (n_extra) begin
            tag = $urandom();
            if (tag == TAG_DATA) tag = ~tag;
            clen = $urandom_range(0, 9);
            put_tag(tag);
            put_le(32'(clen), 4);
            repeat (clen) put_byte(8'($urandom()));
        end
        put_tag(TAG_DATA);
        put_le(body_size, 4);
        sb = (depth >= 16 && depth <= 32) ? int'(depth >> 3) : 2;
        for (int i = 0; i < body_len; i++) begin
            idx = i / sb;
            if (i % sb != 0)  put_byte(8'($urandom()));
            else if (idx < 4) put_byte(8'((msg_len ^ salt) >> (8 * idx)));
            else if (idx < 8) put_byte(8'(salt >> (8 * (idx - 4))));
            else              put_byte(8'($urandom()));
        end
        repeat (tail_len) put_byte(8'($urandom()));
        mark_eof();
    endtask

    // Drive the queued file one transaction at a time. tvalid stays high into the next file
    // when no gap is drawn, so it is only ever assigned once per time step.
    task automatic send_file();
        int gap;
        foreach (file_q[i]) begin
            gap = src_gaps ? pick_gap() : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= file_q[i].file_byte;
            s_tlast  <= file_q[i].end_of_file;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
        end
        file_q.delete();
    endtask

    // Hold the source until every predicted result has been seen.
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    initial begin
        int          rnd_sent;
        int          kind;
        int          r;
        int          sb;
        int          n_pay;
        logic [15:0] depth;
        logic [15:0] fmt_c;
        logic [31:0] msg_len;
        logic [31:0] body_size;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn     <= 1'b1;
        sink_stalls <= 1'b1;
        src_gaps     = 1'b1;

        // ---- directed files ----
        // lone byte flagged end of file while still in the RIFF header
        put_byte(8'hFF);
        mark_eof();
        send_file();
        // data chunk right at byte 12: depth not yet seen, so bad depth
        build_wav(FORMAT_PCM, 16'd16, 1'b0, 0, 32'd4, 32'd1, 0, 0);
        send_file();
        // plain 16-bit file, payload ends on the encoded length
        build_wav(FORMAT_PCM, 16'd16, 1'b1, 0, 32'd22, 32'd3, 22, 0);
        send_file();
        // non-PCM format, filler chunks, data chunk ends on a payload byte
        build_wav(16'hFFFE, 16'd24, 1'b1, 2, 32'd28, 32'd5, 28, 0);
        send_file();
        // data chunk ends one byte after a payload byte: done with nothing on that step
        build_wav(FORMAT_PCM, 16'd16, 1'b1, 0, 32'd20, 32'd6, 20, 0);
        send_file();
        // masked length decodes to zero, stray bytes after the end
        build_wav(FORMAT_PCM, 16'd32, 1'b1, 0, 32'd40, 32'd0, 40, 2);
        send_file();
        // empty data chunk
        build_wav(FORMAT_PCM, 16'd16, 1'b1, 1, 32'd0, 32'd4, 0, 3);
        send_file();
        // data chunk ends inside the salt samples
        build_wav(FORMAT_PCM, 16'd16, 1'b1, 0, 32'd12, 32'd4, 12, 0);
        send_file();
        // depths out of range on both sides, and one with the top bit set
        build_wav(FORMAT_PCM, 16'd8, 1'b1, 0, 32'd16, 32'd2, 4, 0);
        send_file();
        build_wav(FORMAT_PCM, 16'd33, 1'b1, 0, 32'd16, 32'd2, 4, 0);
        send_file();
        build_wav(FORMAT_PCM, 16'h8000, 1'b1, 0, 32'd16, 32'd2, 4, 0);
        send_file();
        // depth that is not a multiple of 8 rounds down to whole bytes
        build_wav(FORMAT_PCM, 16'd17, 1'b1, 0, 32'd20, 32'd2, 20, 0);
        send_file();
        // end of file lands on a payload byte mid-message
        build_wav(FORMAT_PCM, 16'd32, 1'b1, 0, 32'd72, 32'd10, 45, 0);
        send_file();
        // end of file inside a chunk header and inside a skipped chunk body
        build_wav(FORMAT_PCM, 16'd16, 1'b1, 0, 32'd22, 32'd3, 22, 0);
        cut_file(15);
        send_file();
        build_wav(FORMAT_PCM, 16'd16, 1'b1, 0, 32'd22, 32'd3, 22, 0);
        cut_file(25);
        send_file();
        // all-ones size and length, stream stops on a non-first sample byte
        build_wav(FORMAT_PCM, 16'd16, 1'b1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 30, 0);
        send_file();

        // pause the source until the directed results have drained
        wait_quiet();

        // ---- random files ----
        rnd_sent = 0;
        while (rnd_sent < RANDOM_BYTES) begin
            src_gaps     = ($urandom_range(0, 3) != 0);
            sink_stalls <= ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            if (kind < 9) begin
                r = $urandom_range(0, 99);
                if (r < 30)      depth = 16'd16;
                else if (r < 55) depth = 16'd24;
                else if (r < 80) depth = 16'd32;
                else if (r < 90) depth = 16'($urandom_range(17, 31));
                else begin
                    case ($urandom_range(0, 3))
                        0:       depth = 16'($urandom_range(0, 15));
                        1:       depth = 16'($urandom_range(33, 255));
                        2:       depth = 16'h8000 | 16'($urandom());
                        default: depth = 16'($urandom());
                    endcase
                end
                fmt_c = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : FORMAT_PCM;
                sb    = (depth >= 16 && depth <= 32) ? int'(depth >> 3) : 2;
                n_pay = $urandom_range(0, 20);
                case ($urandom_range(0, 9))
                    0:       msg_len = '0;
                    1, 2:    msg_len = 32'(n_pay + $urandom_range(1, 8));
                    3:       msg_len = $urandom();
                    default: msg_len = 32'($urandom_range(1, (n_pay > 0) ? n_pay : 1));
                endcase
                body_size = 32'((8 + n_pay) * sb);
                r = $urandom_range(0, 9);
                if (r < 2)       body_size = body_size - 32'($urandom_range(0, sb - 1));
                else if (r == 2) body_size = 32'($urandom_range(0, 8 * sb));
                build_wav(fmt_c, depth, ($urandom_range(0, 19) != 0), $urandom_range(0, 2),
                          body_size, msg_len, int'(body_size),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
                // broken files: stop the stream at a random byte
                if (kind >= 7) cut_file($urandom_range(1, file_q.size()));
            end else begin
                // noise: random bytes with a random end
                repeat ($urandom_range(1, 48)) put_byte(8'($urandom()));
                mark_eof();
            end
            rnd_sent += file_q.size();
            send_file();
            if ($urandom_range(0, 7) == 0) wait_quiet();
        end

        // drain: nothing pending, then a few more cycles for any stray result
        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
